### hw/rtl/msp_pkg.sv
package msp_pkg;

    // Field widths of the request and result
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int POS_W   = 16;
    localparam int STAT_W  = 3;

    // Result tdata: status, value, error position, padded to whole bytes
    localparam int RES_BITS = STAT_W + VALUE_W + POS_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

    // Default size unit base (1000 or 1024)
    localparam int UNIT_BASE_DEF = 1024;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK            = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY         = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW      = 3'd2;
    localparam logic [STAT_W-1:0] ST_INVALID_DIGIT = 3'd3;
    localparam logic [STAT_W-1:0] ST_INVALID_SCALE = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_K     = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h47;

    // Size suffix selector
    typedef enum logic [1:0] {
        SC_NONE = 2'd0,
        SC_K    = 2'd1,
        SC_M    = 2'd2,
        SC_G    = 2'd3
    } t_scale;

    // Control from the parser to the suffix scaler
    typedef struct packed {
        logic   load_first;
        logic   load_second;
        t_scale scale;
    } t_scale_ctl;

    // One result
    typedef struct packed {
        logic [POS_W-1:0]   error_position;
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
    } t_result;

endpackage

### hw/rtl/msp_scaler.sv
module msp_scaler
    import msp_pkg::*;
#(
    parameter int UNIT_BASE = UNIT_BASE_DEF
) (
    input  logic               i_clk,
    input  t_scale_ctl         i_ctl,
    input  logic [VALUE_W-1:0] i_acc,
    output logic [VALUE_W-1:0] o_prod,
    output logic               o_ovf
);

    localparam int BASE_W = $clog2(UNIT_BASE + 1);
    localparam int P1_W   = VALUE_W + BASE_W;
    localparam int M2_W   = 2 * BASE_W;
    localparam int P2_W   = VALUE_W + M2_W;

    localparam logic [BASE_W-1:0] BASE_C    = BASE_W'(UNIT_BASE);
    localparam logic [M2_W-1:0]   BASE_SQ_C = M2_W'(UNIT_BASE * UNIT_BASE);

    logic [VALUE_W-1:0] r_prod;
    logic               r_ovf;
    logic [P1_W-1:0]    w_p1;
    logic [P1_W-1:0]    w_p2_m;
    logic [P2_W-1:0]    w_p2_g;
    logic [P2_W-1:0]    w_p2;

    // First step: number times one unit
    assign w_p1 = P1_W'(i_acc) * P1_W'(BASE_C);

    // Second step: remaining power of the unit, each a product by a constant
    assign w_p2_m = P1_W'(r_prod) * P1_W'(BASE_C);
    assign w_p2_g = P2_W'(r_prod) * P2_W'(BASE_SQ_C);

    always_comb begin
        case (i_ctl.scale)
            SC_M:    w_p2 = P2_W'(w_p2_m);
            SC_G:    w_p2 = w_p2_g;
            default: w_p2 = P2_W'(r_prod);
        endcase
    end

    // Hold the product and a sticky overflow flag
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_first) begin
            r_prod <= w_p1[VALUE_W-1:0];
            r_ovf  <= |w_p1[P1_W-1:VALUE_W];
        end else if (i_ctl.load_second) begin
            r_prod <= w_p2[VALUE_W-1:0];
            r_ovf  <= r_ovf | (|w_p2[P2_W-1:VALUE_W]);
        end
    end

    assign o_prod = r_prod;
    assign o_ovf  = r_ovf;

endmodule

### hw/rtl/msp_parser.sv
module msp_parser
    import msp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [CHAR_W-1:0]  i_char,
    input  logic [VALUE_W-1:0] i_prod,
    input  logic               i_prod_ovf,
    output logic [VALUE_W-1:0] o_acc,
    output t_scale_ctl         o_scale_ctl,
    output logic               o_load,
    output t_result            o_result
);

    localparam int SUM_W = VALUE_W + 4;

    typedef enum logic [7:0] {
        PH_FIRST    = 8'b0000_0001,
        PH_DIGITS   = 8'b0000_0010,
        PH_TAIL_ONE = 8'b0000_0100,
        PH_TAIL_B   = 8'b0000_1000,
        PH_TAIL_I   = 8'b0001_0000,
        PH_TAIL_IB  = 8'b0010_0000,
        PH_TAIL_BAD = 8'b0100_0000,
        PH_HALT     = 8'b1000_0000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [POS_W-1:0]   r_index, n_index;
    t_scale             r_scale, n_scale;
    logic [STAT_W-1:0]  r_err, n_err;
    logic [POS_W-1:0]   r_pos, n_pos;

    logic               w_is_digit;
    logic [3:0]         w_digit;
    logic [SUM_W-1:0]   w_sum;
    logic               w_digit_ovf;
    logic               w_end;

    assign w_end      = (i_char == CH_NUL);
    assign w_is_digit = (i_char >= CH_0) && (i_char <= CH_9);
    assign w_digit    = 4'(i_char - CH_0);

    // Multiply by ten as two shifts, add the digit, flag a carry past 64 bits
    assign w_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + SUM_W'(w_digit);
    assign w_digit_ovf = |w_sum[SUM_W-1:VALUE_W];

    // Form the result for a terminator
    always_comb begin
        o_result = '{error_position: '0, value: '0, status: ST_OK};
        unique case (r_phase)
            PH_FIRST: o_result.status = ST_EMPTY;
            PH_DIGITS: o_result.value = r_acc;
            PH_TAIL_ONE: begin
                if (r_scale == SC_NONE) begin
                    o_result.value = r_acc;
                end else begin
                    o_result.status         = ST_INVALID_SCALE;
                    o_result.error_position = r_pos;
                end
            end
            PH_TAIL_B, PH_TAIL_IB: begin
                if (i_prod_ovf) begin
                    o_result.status         = ST_OVERFLOW;
                    o_result.error_position = r_pos;
                end else begin
                    o_result.value = i_prod;
                end
            end
            PH_TAIL_I, PH_TAIL_BAD: begin
                o_result.status         = ST_INVALID_SCALE;
                o_result.error_position = r_pos;
            end
            PH_HALT: begin
                o_result.status         = r_err;
                o_result.error_position = r_pos;
            end
            default: o_result.status = ST_EMPTY;
        endcase
    end

    assign o_load = i_go && w_end;

    // Advance the parse state for one character
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_index = r_index;
        n_scale = r_scale;
        n_err   = r_err;
        n_pos   = r_pos;
        o_scale_ctl = '{load_first: 1'b0, load_second: 1'b0, scale: r_scale};
        if (i_go && w_end) begin
            n_phase = PH_FIRST;
            n_index = '0;
            n_scale = SC_NONE;
            n_err   = ST_OK;
            n_pos   = '0;
        end else if (i_go) begin
            if (r_index != {POS_W{1'b1}}) begin
                n_index = r_index + POS_W'(1);
            end
            unique case (r_phase)
                PH_FIRST: begin
                    if (w_is_digit) begin
                        n_acc   = VALUE_W'(w_digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_err   = ST_INVALID_DIGIT;
                        n_pos   = '0;
                        n_phase = PH_HALT;
                    end
                end
                PH_DIGITS: begin
                    if (i_char == CH_APOS || i_char == CH_UNDER) begin
                        n_phase = PH_DIGITS;
                    end else if (w_is_digit) begin
                        if (w_digit_ovf) begin
                            n_err   = ST_OVERFLOW;
                            n_pos   = r_index;
                            n_phase = PH_HALT;
                        end else begin
                            n_acc = w_sum[VALUE_W-1:0];
                        end
                    end else begin
                        n_pos = r_index;
                        o_scale_ctl.load_first = 1'b1;
                        n_phase = PH_TAIL_ONE;
                        case (i_char)
                            CH_B:    n_scale = SC_NONE;
                            CH_K:    n_scale = SC_K;
                            CH_M:    n_scale = SC_M;
                            CH_G:    n_scale = SC_G;
                            default: n_phase = PH_TAIL_BAD;
                        endcase
                    end
                end
                PH_TAIL_ONE: begin
                    o_scale_ctl.load_second = 1'b1;
                    if (r_scale == SC_NONE) begin
                        n_phase = PH_TAIL_BAD;
                    end else if (i_char == CH_B) begin
                        n_phase = PH_TAIL_B;
                    end else if (i_char == CH_I) begin
                        n_phase = PH_TAIL_I;
                    end else begin
                        n_phase = PH_TAIL_BAD;
                    end
                end
                PH_TAIL_I: n_phase = (i_char == CH_B) ? PH_TAIL_IB : PH_TAIL_BAD;
                PH_TAIL_B, PH_TAIL_IB: n_phase = PH_TAIL_BAD;
                PH_TAIL_BAD, PH_HALT: n_phase = r_phase;
                default: n_phase = PH_HALT;
            endcase
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_index <= '0;
        end else begin
            r_phase <= n_phase;
            r_index <= n_index;
        end
        r_acc   <= n_acc;
        r_scale <= n_scale;
        r_err   <= n_err;
        r_pos   <= n_pos;
    end

    assign o_acc = r_acc;

`ifndef SYNTHESIS
    // A terminator restarts the parse at index zero
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && w_end) |=> (r_phase == PH_FIRST && r_index == '0))
        else $error("parser did not restart after terminator");

    // A digit overflow is latched and moves to the halt phase
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && !w_end && r_phase == PH_DIGITS && w_is_digit && w_digit_ovf)
        |=> (r_phase == PH_HALT && r_err == ST_OVERFLOW))
        else $error("digit overflow not latched");
`endif

endmodule

### hw/rtl/msp_out_reg.sv
module msp_out_reg
    import msp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_result          i_result,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [RES_W-1:0] o_m_tdata
);

    logic    r_valid;
    t_result r_result;

    // Load a new result or drop the one taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = RES_W'(r_result);

endmodule

### hw/rtl/memory_size_string_parser.sv
// Channel   Dir  tdata bits (low first)                        Moves
// s_*       in   char_code[7:0]                                one byte per request
// m_*       out  status[2:0], value[66:3], error_position[82:67] one result per terminator
//
// One byte is taken every cycle while the output side keeps up.
// A byte is parsed during the cycle it sits in the input register;
// a terminator's result is in the output register from the next edge.
// The suffix multiply is split over the suffix letter and the character after it.
// Reset (i_rst_n low, synchronous) clears the parse and drops any held result.
// A terminator waits in the input register while a previous result is not taken;
// other bytes pass regardless of the output side.
module memory_size_string_parser
    import msp_pkg::*;
#(
    parameter int UNIT_BASE = UNIT_BASE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [CHAR_W-1:0] i_s_tdata,   // char_code[7:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [RES_W-1:0]  o_m_tdata    // status[2:0], value[66:3], error_position[82:67]
);

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               w_out_free;
    logic               w_go;
    logic               w_load;
    t_result            w_result;
    t_scale_ctl         w_scale_ctl;
    logic [VALUE_W-1:0] w_acc;
    logic [VALUE_W-1:0] w_prod;
    logic               w_prod_ovf;

    // Advance the held byte unless it is a terminator with the output full
    assign w_out_free = !o_m_tvalid || i_m_tready;
    assign w_go       = r_in_valid && ((r_in_char != CH_NUL) || w_out_free);
    assign o_s_tready = !r_in_valid || w_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
    end

    msp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_char      (r_in_char),
        .i_prod      (w_prod),
        .i_prod_ovf  (w_prod_ovf),
        .o_acc       (w_acc),
        .o_scale_ctl (w_scale_ctl),
        .o_load      (w_load),
        .o_result    (w_result)
    );

    msp_scaler #(
        .UNIT_BASE (UNIT_BASE)
    ) u_scaler (
        .i_clk  (i_clk),
        .i_ctl  (w_scale_ctl),
        .i_acc  (w_acc),
        .o_prod (w_prod),
        .o_ovf  (w_prod_ovf)
    );

    msp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_result   (w_result),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

`ifndef SYNTHESIS
    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result overwritten");

    // A stalled byte stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_go) |=> (r_in_valid && $stable(r_in_char)))
        else $error("input register lost a byte");

    // Value is zero whenever the status is not ok
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_result.status != ST_OK) |-> (w_result.value == '0))
        else $error("non-zero value with error status");

    // Position is zero for ok and empty results
    a_ok_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_result.status == ST_OK || w_result.status == ST_EMPTY))
        |-> (w_result.error_position == '0))
        else $error("non-zero position without error");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb
    import msp_pkg::*;
;

    localparam int          UNIT     = UNIT_BASE_DEF;
    localparam logic [63:0] MAX_SIZE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          N_RANDOM = 1900;

    // Parse phases of the predictor
    typedef enum logic [2:0] {
        WAIT_FIRST,
        IN_NUMBER,
        AFTER_LETTER,
        GOT_B,
        GOT_I,
        GOT_IB,
        BAD_TAIL,
        HALTED
    } t_phase;

    // Predicts the size result of each string and checks the block's results
    class size_scoreboard;
        t_result     expected_sizes[$];
        int          errors;
        logic [63:0] number;
        t_phase      phase;
        logic [15:0] next_idx;
        t_scale      unit_sel;
        logic [2:0]  err_code;
        logic [15:0] mark_pos;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            number   = '0;
            phase    = WAIT_FIRST;
            next_idx = '0;
            unit_sel = SC_NONE;
            err_code = ST_OK;
            mark_pos = '0;
        endfunction

        function void latch_error(logic [2:0] code, logic [15:0] at);
            err_code = code;
            mark_pos = at;
            phase    = HALTED;
        endfunction

        // Advance the parse by one accepted byte; queue a result at the terminator
        function void note_byte(logic [7:0] c);
            t_result     r;
            logic [15:0] here;
            logic [63:0] digit;
            logic [63:0] mult;
            here  = next_idx;
            digit = {56'd0, c - CH_0};
            if (c == CH_NUL) begin
                r.status         = ST_OK;
                r.value          = '0;
                r.error_position = '0;
                case (phase)
                    WAIT_FIRST: r.status = ST_EMPTY;
                    IN_NUMBER:  r.value = number;
                    AFTER_LETTER: begin
                        if (unit_sel == SC_NONE) begin
                            r.value = number;
                        end else begin
                            r.status         = ST_INVALID_SCALE;
                            r.error_position = mark_pos;
                        end
                    end
                    GOT_B, GOT_IB: begin
                        mult = 64'(UNIT);
                        if (unit_sel == SC_M) mult = 64'(UNIT) * 64'(UNIT);
                        if (unit_sel == SC_G) mult = 64'(UNIT) * 64'(UNIT) * 64'(UNIT);
                        if (number > MAX_SIZE / mult) begin
                            r.status         = ST_OVERFLOW;
                            r.error_position = mark_pos;
                        end else begin
                            r.value = number * mult;
                        end
                    end
                    GOT_I, BAD_TAIL: begin
                        r.status         = ST_INVALID_SCALE;
                        r.error_position = mark_pos;
                    end
                    default: begin
                        r.status         = err_code;
                        r.error_position = mark_pos;
                    end
                endcase
                expected_sizes.push_back(r);
                clear();
                return;
            end

            if (next_idx != 16'hFFFF) next_idx = next_idx + 16'd1;

            case (phase)
                WAIT_FIRST: begin
                    if (c >= CH_0 && c <= CH_9) begin
                        number = digit;
                        phase  = IN_NUMBER;
                    end else begin
                        latch_error(ST_INVALID_DIGIT, 16'd0);
                    end
                end
                IN_NUMBER: begin
                    if (c == CH_APOS || c == CH_UNDER) begin
                        // skip separators
                    end else if (c >= CH_0 && c <= CH_9) begin
                        if (number > (MAX_SIZE - digit) / 64'd10)
                            latch_error(ST_OVERFLOW, here);
                        else
                            number = number * 64'd10 + digit;
                    end else begin
                        mark_pos = here;
                        phase    = AFTER_LETTER;
                        case (c)
                            CH_B:    unit_sel = SC_NONE;
                            CH_K:    unit_sel = SC_K;
                            CH_M:    unit_sel = SC_M;
                            CH_G:    unit_sel = SC_G;
                            default: phase = BAD_TAIL;
                        endcase
                    end
                end
                AFTER_LETTER: begin
                    if (unit_sel == SC_NONE) phase = BAD_TAIL;
                    else if (c == CH_B)      phase = GOT_B;
                    else if (c == CH_I)      phase = GOT_I;
                    else                     phase = BAD_TAIL;
                end
                GOT_I:         phase = (c == CH_B) ? GOT_IB : BAD_TAIL;
                GOT_B, GOT_IB: phase = BAD_TAIL;
                default: ;
            endcase
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(logic [RES_W-1:0] data);
            t_result got;
            t_result want;
            got = t_result'(data[RES_BITS-1:0]);
            if (expected_sizes.size() == 0) begin
                $error("unexpected result: status %0d value %0d error_position %0d",
                       got.status, got.value, got.error_position);
                errors++;
                return;
            end
            want = expected_sizes.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, got.value);
                errors++;
            end
            if (got.error_position !== want.error_position) begin
                $error("error_position: expected %0d, got %0d",
                       want.error_position, got.error_position);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [CHAR_W-1:0] i_s_tdata  = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [RES_W-1:0]  o_m_tdata;

    size_scoreboard board = new();
    logic           calm  = 1'b0;
    int             n_sent = 0;
    logic [7:0]     text[$];

    memory_size_string_parser #(
        .UNIT_BASE(UNIT)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at random except in the calm stretch
    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
            board.check_result(o_m_tdata);
    end

    // Offer one byte, with a random idle cycle in front, and hold it until taken
    task automatic send_byte(input logic [7:0] c);
        if (!calm && $urandom_range(99) < 15) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_byte(c);
        n_sent++;
    endtask

    // Send the text buffer followed by a terminator, then clear the buffer
    task automatic send_text();
        foreach (text[k]) send_byte(text[k]);
        send_byte(CH_NUL);
        text.delete();
    endtask

    task automatic send_literal(input string s);
        for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
        send_text();
    endtask

    // Append a random number of n digits, with separators now and then
    task automatic add_digits(input int n);
        text.push_back(CH_0 + 8'($urandom_range(9)));
        for (int k = 1; k < n; k++) begin
            if ($urandom_range(9) == 0)
                text.push_back($urandom_range(1) ? CH_APOS : CH_UNDER);
            text.push_back(CH_0 + 8'($urandom_range(9)));
        end
    endtask

    task automatic add_suffix(input string s);
        for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
    endtask

    function automatic logic [7:0] tail_char();
        logic [7:0] pick[7];
        pick = '{CH_B, CH_K, CH_M, CH_G, CH_I, CH_0, 8'h78};
        if ($urandom_range(3) == 0) return 8'($urandom_range(1, 255));
        return pick[$urandom_range(6)];
    endfunction

    initial begin
        string suffixes[8];
        int    kind;
        suffixes = '{"", "B", "KB", "MB", "GB", "KiB", "MiB", "GiB"};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings: empty, bad first byte, extremes, suffixes B, KB, MiB, GiB and GB, bad tails
        send_literal("");
        send_literal("K");
        text.push_back(8'hFF);
        send_text();
        send_literal("0");
        send_literal("18446744073709551615");
        send_literal("18446744073709551616");
        send_literal("1'000_000");
        send_literal("_5");
        send_literal("5B");
        send_literal("4KB");
        send_literal("3MiB");
        send_literal("2GiB");
        send_literal("17179869184GB");
        send_literal("7K");
        send_literal("7BB");
        send_literal("7Ki");
        send_literal("7KiBx");
        send_literal("12a34");
        send_literal("99999999999999999999KB");

        // Random strings, mostly well formed
        while (n_sent < N_RANDOM) begin
            calm = (n_sent > 800 && n_sent < 1100);
            kind = $urandom_range(99);
            if (kind < 70) begin
                add_digits($urandom_range(1, 20));
                add_suffix(suffixes[$urandom_range(7)]);
            end else if (kind < 85) begin
                add_digits($urandom_range(1, 12));
                repeat ($urandom_range(1, 3)) text.push_back(tail_char());
            end else if (kind < 95) begin
                repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
            end else begin
                repeat (21) text.push_back(CH_9);
                repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(1, 255)));
            end
            send_text();
        end
        calm = 1'b0;

        i_s_tvalid <= 1'b0;
        while (board.expected_sizes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Hang guard
    initial begin
        #50_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
